[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the deframer.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPRD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LPRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/lprd_pkg.sv]
// Types and constants for the length-prefixed record deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lprd_pkg;

	localparam int SIZE_W    = 24;  // image_size, record_start, record_length
	localparam int INDEX_W   = 6;
	localparam int FOUND_W   = 7;
	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 32;  // raw header length word
	localparam int POS_CMP_W = 33;  // position compares, no wrap for address widths up to 32
	localparam int HDR_BYTES = 4;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	// register index, taken from paddr[2]
	localparam logic REG_IMAGE_SIZE = 1'b0;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_PADDING = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ROLE_HEADER  = 2'd0,
		ROLE_PAYLOAD = 2'd1,
		ROLE_PADDING = 2'd2,
		ROLE_IGNORED = 2'd3
	} role_t;

	typedef enum logic [2:0] {
		ST_RUN    = 3'd0,
		ST_NODATA = 3'd1,
		ST_SHORT  = 3'd2,
		ST_BADLEN = 3'd3,
		ST_FULL   = 3'd4,
		ST_DONE   = 3'd5
	} status_t;

	typedef struct packed {
		role_t                byte_role;
		logic                 record_valid;
		logic [INDEX_W-1:0]   record_index;
		logic [SIZE_W-1:0]    record_start;
		logic [SIZE_W-1:0]    record_length;
		status_t              parse_status;
		logic [FOUND_W-1:0]   records_found;
	} lprd_result_t;

endpackage

`default_nettype wire

[rtl/length_prefixed_record_deframer.sv]
// Length-prefixed record deframer: takes an image one byte per beat and tags
// each byte as header, payload, padding or ignored, reporting every accepted
// record's index, payload offset and length and the running parse status.
// Records are a 4-byte big-endian length, the payload, then padding to the
// next 4-byte boundary. Throughput is one byte per clock while result_stall
// is low: a byte sits in the input register while the single-pass parse
// logic updates the position counter and the parse state, and its result
// is registered in the output register. The output register decouples the
// two sides: a new byte is taken while a finished result waits, and stall
// backs up only when both stages are full. Once the parse stops (no data,
// short header, bad length, table full, finished) every later byte is
// reported as ignored with the stop status repeated. image_size is written
// over the APB-style port at byte address 0 and should only be changed while
// no byte is in flight.
// Depends on lprd_pkg and lprd_parser.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_record_deframer #(
	parameter int MAX_RECORDS     = 64,
	parameter int IMAGE_ADDR_BITS = 24
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration port
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [lprd_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [lprd_pkg::PDATA_W-1:0]    pwdata,
	output logic      [lprd_pkg::PDATA_W-1:0]    prdata,
	output logic                                 pready,
	// byte input
	input  wire logic                            byte_valid,
	output logic                                 byte_stall,
	input  wire logic [lprd_pkg::BYTE_W-1:0]     image_byte,
	// result output
	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output logic      [1:0]                      byte_role,
	output logic                                 record_valid,
	output logic      [lprd_pkg::INDEX_W-1:0]    record_index,
	output logic      [lprd_pkg::SIZE_W-1:0]     record_start,
	output logic      [lprd_pkg::SIZE_W-1:0]     record_length,
	output logic      [2:0]                      parse_status,
	output logic      [lprd_pkg::FOUND_W-1:0]    records_found
);
	import lprd_pkg::*;

	// configuration register
	logic [SIZE_W-1:0] image_size_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[2])
			REG_IMAGE_SIZE: prdata = PDATA_W'(image_size_q);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q <= '0;
		end else if (cfg_wr && paddr[2] == REG_IMAGE_SIZE) begin
			image_size_q <= pwdata[SIZE_W-1:0];
		end
	end

	// input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              advance, take_in, step;

	// output stage
	lprd_result_t res_d, res_q;
	logic         res_valid_q;

	// s1 moves on when the output register is empty or being drained
	assign advance    = !res_valid_q || !result_stall;
	assign byte_stall = valid_s1 && !advance;
	assign take_in    = byte_valid && !byte_stall;
	assign step       = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take_in || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (take_in)
			byte_s1 <= image_byte;
	end

	lprd_parser #(
		.MAX_RECORDS     (MAX_RECORDS),
		.IMAGE_ADDR_BITS (IMAGE_ADDR_BITS)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.image_byte (byte_s1),
		.image_size (image_size_q),
		.result     (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= step || (res_valid_q && result_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			res_q <= res_d;
	end

	assign result_valid  = res_valid_q;
	assign byte_role     = res_q.byte_role;
	assign record_valid  = res_q.record_valid;
	assign record_index  = res_q.record_index;
	assign record_start  = res_q.record_start;
	assign record_length = res_q.record_length;
	assign parse_status  = res_q.parse_status;
	assign records_found = res_q.records_found;

endmodule

`default_nettype wire

[rtl/lprd_parser.sv]
// Per-byte parse state and single-pass next-state logic of the deframer.
// Depends on lprd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lprd_parser #(
	parameter int MAX_RECORDS     = 64,
	parameter int IMAGE_ADDR_BITS = 24
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire logic [lprd_pkg::BYTE_W-1:0]   image_byte,
	input  wire logic [lprd_pkg::SIZE_W-1:0]   image_size,
	output lprd_pkg::lprd_result_t             result
);
	import lprd_pkg::*;

	localparam int PW   = IMAGE_ADDR_BITS;
	localparam int CNTW = $clog2(MAX_RECORDS + 1);
	localparam int EXW  = (CNTW > FOUND_W) ? CNTW : FOUND_W;

	logic [PW-1:0]     pos_q, pos_d, pos_inc;
	phase_t            phase_q, phase_d;
	logic [1:0]        hbs_q, hbs_d;
	logic [LEN_W-1:0]  len_q, len_d, len_base, len_new;
	logic [SIZE_W-1:0] left_q, left_d, left_dec;
	logic [CNTW-1:0]   count_q, count_d;
	status_t           stop_q, stop_d;

	logic                 consume, rec_ok, len_bad;
	logic [POS_CMP_W-1:0] size_x, pos_x, pos_inc_x, rem;
	logic [EXW-1:0]       count_x, count_prev, count_d_x;

	assign size_x    = POS_CMP_W'(image_size);
	assign pos_x     = POS_CMP_W'(pos_q);
	assign pos_inc   = pos_q + PW'(1);
	assign pos_inc_x = POS_CMP_W'(pos_inc);
	assign rem       = (size_x > pos_inc_x) ? (size_x - pos_inc_x) : '0;

	assign len_base = (hbs_q == 2'd0) ? '0 : len_q;
	assign len_new  = {len_base[LEN_W-BYTE_W-1:0], image_byte};
	assign len_bad  = (len_new == '0) || (POS_CMP_W'(len_new) > rem);
	assign left_dec = (left_q != '0) ? (left_q - SIZE_W'(1)) : left_q;

	assign count_x    = EXW'(count_q);
	assign count_prev = count_x - EXW'(1);
	assign count_d_x  = EXW'(count_d);

	// next state
	always_comb begin
		consume = 1'b0;
		rec_ok  = 1'b0;
		stop_d  = stop_q;
		pos_d   = pos_q;
		phase_d = phase_q;
		hbs_d   = hbs_q;
		len_d   = len_q;
		left_d  = left_q;
		count_d = count_q;

		if (stop_q == ST_RUN) begin
			if (image_size == '0) begin
				stop_d = ST_NODATA;
			end else if (phase_q == PH_HEADER && hbs_q == 2'd0) begin
				if (pos_x >= size_x)
					stop_d = ST_DONE;
				else if (count_q >= CNTW'(MAX_RECORDS))
					stop_d = ST_FULL;
				else if (pos_x + POS_CMP_W'(HDR_BYTES) > size_x)
					stop_d = ST_SHORT;
				else
					consume = 1'b1;
			end else if (phase_q == PH_PADDING) begin
				if (pos_x >= size_x)
					stop_d = ST_DONE;
				else
					consume = 1'b1;
			end else begin
				consume = 1'b1;
			end
		end

		if (consume) begin
			pos_d = pos_inc;
			unique case (phase_q)
				PH_PAYLOAD: begin
					left_d = left_dec;
					if (left_dec == '0)
						phase_d = (pos_inc[1:0] != 2'd0) ? PH_PADDING : PH_HEADER;
				end
				PH_PADDING: begin
					if (pos_inc[1:0] == 2'd0)
						phase_d = PH_HEADER;
				end
				default: begin
					len_d = len_new;
					if (hbs_q == 2'(HDR_BYTES - 1)) begin
						hbs_d = 2'd0;
						if (len_bad) begin
							stop_d = ST_BADLEN;
						end else begin
							rec_ok  = 1'b1;
							count_d = count_q + CNTW'(1);
							left_d  = len_new[SIZE_W-1:0];
							phase_d = PH_PAYLOAD;
						end
					end else begin
						hbs_d = hbs_q + 2'd1;
					end
				end
			endcase
			// a consumed byte always moves the position to pos_inc
			if (stop_d == ST_RUN && pos_inc_x >= size_x &&
			    ((phase_d == PH_HEADER && hbs_d == 2'd0) || phase_d == PH_PADDING))
				stop_d = ST_DONE;
		end
	end

	// result fields
	always_comb begin
		result               = '0;
		result.byte_role     = ROLE_IGNORED;
		result.parse_status  = stop_d;
		result.records_found = count_d_x[FOUND_W-1:0];
		if (consume) begin
			unique case (phase_q)
				PH_PAYLOAD: begin
					result.byte_role    = ROLE_PAYLOAD;
					result.record_index = count_prev[INDEX_W-1:0];
				end
				PH_PADDING: begin
					result.byte_role    = ROLE_PADDING;
					result.record_index = count_prev[INDEX_W-1:0];
				end
				default: begin
					result.byte_role    = ROLE_HEADER;
					result.record_index = count_x[INDEX_W-1:0];
				end
			endcase
		end
		if (rec_ok) begin
			result.record_valid  = 1'b1;
			result.record_start  = pos_inc_x[SIZE_W-1:0];
			result.record_length = len_new[SIZE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= PH_HEADER;
			hbs_q   <= '0;
			len_q   <= '0;
			left_q  <= '0;
			count_q <= '0;
			stop_q  <= ST_RUN;
		end else if (step) begin
			pos_q   <= pos_d;
			phase_q <= phase_d;
			hbs_q   <= hbs_d;
			len_q   <= len_d;
			left_q  <= left_d;
			count_q <= count_d;
			stop_q  <= stop_d;
		end
	end

endmodule

`default_nettype wire

[rtl/lprd_checker.sv]
// Port-level assertions for the deframer, bound to the top level.
// Depends on lprd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lprd_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          result_valid,
	input  wire logic                          result_stall,
	input  wire logic [1:0]                    byte_role,
	input  wire logic                          record_valid,
	input  wire logic [lprd_pkg::INDEX_W-1:0]  record_index,
	input  wire logic [lprd_pkg::SIZE_W-1:0]   record_length,
	input  wire logic [2:0]                    parse_status,
	input  wire logic [lprd_pkg::FOUND_W-1:0]  records_found
);
	import lprd_pkg::*;

	// an accepted header leaves the parse running with a nonzero length
	`LPRD_ASSERT_NOW(a_rec_hdr, clk, arst_n, result_valid && record_valid, byte_role == ROLE_HEADER && parse_status == ST_RUN && record_length != '0 && records_found != '0, "record reported off a clean header byte")

	// ignored bytes only appear once stopped, and carry no record
	`LPRD_ASSERT_NOW(a_ign_stop, clk, arst_n, result_valid && byte_role == ROLE_IGNORED, parse_status != ST_RUN && !record_valid && record_index == '0, "ignored byte while parse running")

	// an empty image consumes nothing
	`LPRD_ASSERT_NOW(a_nodata, clk, arst_n, result_valid && parse_status == ST_NODATA, byte_role == ROLE_IGNORED && !record_valid, "byte consumed with no data")

	// a stalled result holds
	`LPRD_ASSERT_NEXT(a_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(byte_role) && $stable(parse_status) && $stable(records_found), "stalled result changed")

endmodule

bind length_prefixed_record_deframer lprd_checker u_lprd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.result_valid  (result_valid),
	.result_stall  (result_stall),
	.byte_role     (byte_role),
	.record_valid  (record_valid),
	.record_index  (record_index),
	.record_length (record_length),
	.parse_status  (parse_status),
	.records_found (records_found)
);

`default_nettype wire

[tb/sv/length_prefixed_record_deframer_test.sv]
// Self-checking testbench for length_prefixed_record_deframer: feeds record images byte by byte,
// predicts each result beat in a cycle-free parse model and compares field by field.
// Depends on lprd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module length_prefixed_record_deframer_test;
	import lprd_pkg::*;

	localparam int MAX_RECORDS     = 64;
	localparam int IMAGE_ADDR_BITS = 24;
	localparam logic [PADDR_W-1:0] IMAGE_SIZE_ADDR = {REG_IMAGE_SIZE, 2'b00};
	localparam logic [SIZE_W-1:0]  SIZE_MAX = '1;
	localparam int DRAIN_LIMIT = 100000;
	localparam int TAIL_CYCLES = 4;     // settling tail after the last result is seen
	localparam int BODY_RECORDS = 58;   // leave headroom below the record limit
	localparam int BODY_BYTES   = 1900;

	// idle percentages per traffic phase: none, sender gaps, receiver stalls, both
	localparam int SEND_IDLE[4]  = '{0, 57, 0, 30};
	localparam int RECV_STALL[4] = '{0, 0, 57, 30};

	// how the image is brought to a stop at the end of the run
	typedef enum int {
		END_NATURAL,  // image size reached after a consumed byte
		END_SHRINK,   // size rewritten at or below the position mid-payload
		END_FULL,     // record limit hit
		END_SHORT,    // 1..3 bytes left at a header start
		END_BADLEN,   // zero length, huge length or one past the remaining bytes
		END_NODATA    // size set to zero
	} ending_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 psel         = 1'b0;
	logic                 penable      = 1'b0;
	logic                 pwrite       = 1'b0;
	logic [PADDR_W-1:0]   paddr        = '0;
	logic [PDATA_W-1:0]   pwdata       = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	logic                 byte_valid   = 1'b0;
	logic                 byte_stall;
	logic [BYTE_W-1:0]    image_byte   = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic [1:0]           byte_role;
	logic                 record_valid;
	logic [INDEX_W-1:0]   record_index;
	logic [SIZE_W-1:0]    record_start;
	logic [SIZE_W-1:0]    record_length;
	logic [2:0]           parse_status;
	logic [FOUND_W-1:0]   records_found;

	length_prefixed_record_deframer #(
		.MAX_RECORDS     (MAX_RECORDS),
		.IMAGE_ADDR_BITS (IMAGE_ADDR_BITS)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.image_byte    (image_byte),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.byte_role     (byte_role),
		.record_valid  (record_valid),
		.record_index  (record_index),
		.record_start  (record_start),
		.record_length (record_length),
		.parse_status  (parse_status),
		.records_found (records_found)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Image bytes are planned ahead in image_plan, moved phase by phase into
	// pending_bytes for the driver; expected_results holds one parse result per
	// byte taken, oldest first.
	logic [BYTE_W-1:0] image_plan[$];
	logic [BYTE_W-1:0] pending_bytes[$];
	lprd_result_t      expected_results[$];
	int unsigned       plan_pos     = 0;   // image offset of the next planned byte
	int unsigned       plan_records = 0;
	int                send_idle_pct  = 0;
	int                recv_stall_pct = 0;
	int                fail_count   = 0;
	int                bytes_taken  = 0;
	int                size_writes  = 0;

	// Parser state as the block should hold it, plus our copy of image_size.
	logic [SIZE_W-1:0]  cfg_size    = '0;
	logic [SIZE_W-1:0]  pos_count   = '0;
	phase_t             cur_phase   = PH_HEADER;
	logic [2:0]         hdr_count   = '0;
	logic [LEN_W-1:0]   len_word    = '0;
	logic [SIZE_W-1:0]  payload_rem = '0;
	logic [FOUND_W-1:0] rec_total   = '0;
	status_t            halt_status = ST_RUN;

	// One byte through the parser: stop checks first, then the byte is either
	// consumed (header, payload, padding) or reported as ignored.
	function automatic lprd_result_t deframe_byte(input logic [BYTE_W-1:0] b);
		lprd_result_t       r;
		logic               take;
		logic [FOUND_W-1:0] cur_rec;
		logic [SIZE_W-1:0]  rem;
		r = '0;
		r.byte_role = ROLE_IGNORED;
		take = 1'b0;
		cur_rec = rec_total - 1'b1;
		if (halt_status == ST_RUN) begin
			if (cfg_size == '0) begin
				halt_status = ST_NODATA;
			end else if (cur_phase == PH_HEADER && hdr_count == '0) begin
				// header start: end of image beats the record limit beats a short tail
				if (pos_count >= cfg_size)
					halt_status = ST_DONE;
				else if (rec_total >= MAX_RECORDS)
					halt_status = ST_FULL;
				else if (32'(pos_count) + HDR_BYTES > 32'(cfg_size))
					halt_status = ST_SHORT;
				else
					take = 1'b1;
			end else if (cur_phase == PH_PADDING) begin
				if (pos_count >= cfg_size)
					halt_status = ST_DONE;
				else
					take = 1'b1;
			end else begin
				// mid-header and payload bytes always go through
				take = 1'b1;
			end
		end

		if (take) begin
			case (cur_phase)
				PH_PAYLOAD: begin
					r.byte_role = ROLE_PAYLOAD;
					r.record_index = cur_rec[INDEX_W-1:0];
					pos_count = pos_count + 1'b1;
					if (payload_rem != '0)
						payload_rem = payload_rem - 1'b1;
					if (payload_rem == '0)
						cur_phase = (pos_count[1:0] != 2'd0) ? PH_PADDING : PH_HEADER;
				end
				PH_PADDING: begin
					r.byte_role = ROLE_PADDING;
					r.record_index = cur_rec[INDEX_W-1:0];
					pos_count = pos_count + 1'b1;
					if (pos_count[1:0] == 2'd0)
						cur_phase = PH_HEADER;
				end
				default: begin
					r.byte_role = ROLE_HEADER;
					r.record_index = rec_total[INDEX_W-1:0];
					// big-endian length, restarted on the first header byte
					len_word = (hdr_count == '0) ? {24'd0, b} : {len_word[LEN_W-9:0], b};
					hdr_count = hdr_count + 1'b1;
					pos_count = pos_count + 1'b1;
					if (hdr_count == HDR_BYTES) begin
						rem = (cfg_size > pos_count) ? cfg_size - pos_count : '0;
						hdr_count = '0;
						if (len_word == '0 || len_word > LEN_W'(rem)) begin
							halt_status = ST_BADLEN;
						end else begin
							r.record_valid = 1'b1;
							r.record_start = pos_count;
							r.record_length = len_word[SIZE_W-1:0];
							rec_total = rec_total + 1'b1;
							payload_rem = len_word[SIZE_W-1:0];
							cur_phase = PH_PAYLOAD;
						end
					end
				end
			endcase
			// image exhausted at a record boundary or inside padding
			if (halt_status == ST_RUN && pos_count >= cfg_size &&
					((cur_phase == PH_HEADER && hdr_count == '0) || cur_phase == PH_PADDING))
				halt_status = ST_DONE;
		end

		r.parse_status = halt_status;
		r.records_found = rec_total;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Byte driver: predicts on every accepted beat, then offers the next
	// planned byte unless a random gap is taken. A stalled byte is held.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			image_byte <= '0;
		end else begin
			if (byte_valid && !byte_stall) begin
				expected_results.push_back(deframe_byte(image_byte));
				bytes_taken++;
			end
			if (!byte_valid || !byte_stall) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					byte_valid <= 1'b1;
					image_byte <= pending_bytes.pop_front();
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: every accepted beat is matched against the oldest
	// prediction; stall is redrawn each cycle.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		lprd_result_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					$error("result beat with no byte outstanding");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("byte_role", want.byte_role, byte_role);
					check_field("record_valid", want.record_valid, record_valid);
					check_field("record_index", want.record_index, record_index);
					check_field("record_start", want.record_start, record_start);
					check_field("record_length", want.record_length, record_length);
					check_field("parse_status", want.parse_status, parse_status);
					check_field("records_found", want.records_found, records_found);
				end
			end
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// APB write followed straight by a read of the same register.
	task automatic write_image_size(input logic [SIZE_W-1:0] value);
		logic [PDATA_W-1:0] readback;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= IMAGE_SIZE_ADDR;
		pwdata <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// write completes at this edge; psel stays up into the read setup
		cfg_size = value;
		size_writes++;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		readback = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		check_field("image_size readback", PDATA_W'(value), PDATA_W'(readback[SIZE_W-1:0]));
	endtask

	// Wait until every byte is taken and every result seen, then a short tail.
	task automatic drain_beats();
		int guard;
		guard = 0;
		while ((pending_bytes.size() != 0 || byte_valid || expected_results.size() != 0) &&
				guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Set image_size while idle, then stream the next count planned bytes.
	task automatic run_phase(input int unsigned count, input logic [SIZE_W-1:0] size_value);
		write_image_size(size_value);
		repeat (count) pending_bytes.push_back(image_plan.pop_front());
		drain_beats();
	endtask

	function automatic void put_byte(input logic [BYTE_W-1:0] b);
		image_plan.push_back(b);
		plan_pos++;
	endfunction

	function automatic void put_length(input logic [LEN_W-1:0] len);
		for (int i = HDR_BYTES - 1; i >= 0; i--)
			put_byte(len[8*i +: 8]);
	endfunction

	// Well-formed record with random payload; padding zero or random.
	function automatic void add_record(input int unsigned len, input bit noisy_pad);
		put_length(LEN_W'(len));
		repeat (len) put_byte(8'($urandom));
		while (plan_pos % 4 != 0)
			put_byte(noisy_pad ? 8'($urandom) : 8'h00);
		plan_records++;
	endfunction

	// mostly short records, one in ten longer
	function automatic int unsigned pick_length();
		return ($urandom_range(9) == 0) ? $urandom_range(120, 41) : $urandom_range(40, 1);
	endfunction

	initial begin : stimulus
		int unsigned       body_bytes;
		int unsigned       chunk;
		int unsigned       len;
		int unsigned       mark;
		int unsigned       split;
		int                pattern;
		logic [SIZE_W-1:0] size_value;
		ending_t           ending;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero size with nothing in flight: no effect until a byte shows up
		write_image_size('0);

		// Directed head: padding runs of three, two and none, payload and
		// padding bytes at 0x00 and 0xFF.
		put_length(32'd1);
		put_byte(8'hFF);
		put_byte(8'hFF);
		put_byte(8'h00);
		put_byte(8'hFF);
		plan_records++;
		put_length(32'd2);
		put_byte(8'h00);
		put_byte(8'hFF);
		put_byte(8'h00);
		put_byte(8'h00);
		plan_records++;
		put_length(32'd4);
		put_byte(8'h80);
		put_byte(8'h7F);
		put_byte(8'h01);
		put_byte(8'hFE);
		plan_records++;

		// Random body of valid records, split into four traffic phases at
		// arbitrary byte offsets so size writes land inside headers and payloads.
		while (plan_records < BODY_RECORDS && plan_pos < BODY_BYTES)
			add_record(pick_length(), $urandom_range(3) == 0);
		body_bytes = image_plan.size();
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = SEND_IDLE[p];
			recv_stall_pct = RECV_STALL[p];
			chunk = (p == 3) ? image_plan.size() : body_bytes / 4 + $urandom_range(40) - 20;
			case (p)
				0: size_value = SIZE_MAX;
				1: size_value = SIZE_W'($urandom_range(32'hFFFFFF, 32'h10000));
				2: size_value = 24'h800000;
				// tight fit just past the body so it never runs dry
				default: size_value = SIZE_W'(plan_pos + 4 + $urandom_range(255));
			endcase
			run_phase(chunk, size_value);
		end

		// One terminal condition per run, picked at random, then trailing
		// bytes that must all come back ignored with the stop status.
		ending = ending_t'($urandom_range(END_NODATA));
		pattern = $urandom_range(3);
		send_idle_pct = SEND_IDLE[pattern];
		recv_stall_pct = RECV_STALL[pattern];
		size_value = SIZE_MAX;
		case (ending)
			END_NATURAL: begin
				mark = plan_pos;
				len = pick_length();
				add_record(len, 1'b1);
				// image ends after the padding, or right after the payload
				size_value = SIZE_W'($urandom_range(1) ? plan_pos : mark + 4 + len);
			end
			END_SHRINK: begin
				mark = plan_pos;
				len = $urandom_range(40, 8);
				add_record(len, 1'b1);
				split = 4 + $urandom_range(len - 1, 1);
				run_phase(split, SIZE_MAX);
				// accepted payload must still run to its end
				size_value = SIZE_W'($urandom_range(mark + split, 1));
			end
			END_FULL: begin
				while (plan_records < MAX_RECORDS)
					add_record($urandom_range(16, 1), $urandom_range(1));
			end
			END_SHORT: begin
				add_record(pick_length(), 1'b1);
				size_value = SIZE_W'(plan_pos + $urandom_range(3, 1));
			end
			END_BADLEN: begin
				case ($urandom_range(2))
					0: put_length('0);
					1: put_length({8'($urandom_range(255, 1)), 24'($urandom)});
					default: begin
						// one byte more than the image holds after the header
						len = $urandom_range(40, 1);
						size_value = SIZE_W'(plan_pos + 4 + len);
						put_length(LEN_W'(len + 1));
					end
				endcase
			end
			default: size_value = '0;
		endcase
		repeat ($urandom_range(24, 4)) put_byte(8'($urandom));
		run_phase(image_plan.size(), size_value);

		if (expected_results.size() != 0) begin
			$error("%0d result beats never arrived", expected_results.size());
			fail_count++;
		end
		$display("Streamed %0d image bytes across %0d image_size settings.",
			bytes_taken, size_writes);
		$display("Parser accepted %0d records and stopped with status %s.",
			rec_total, halt_status.name());
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#(20_000_000);
		$error("watchdog expired, handshake hung");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
